>>> rtl/byte_ring_deque_assert.svh
// Assertion macros shared by the byte ring deque RTL.
`ifndef BYTE_RING_DEQUE_ASSERT_SVH
`define BYTE_RING_DEQUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte_ring_deque: assertion failed");

// Next-cycle implication.
`define BRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte_ring_deque: assertion failed");

`endif

>>> rtl/brd_pkg.sv
// Shared constants and types for the byte ring deque.
package brd_pkg;

  localparam int BRD_DEPTH   = 256;
  localparam int FUNC_W      = 3;
  localparam int CNT_W       = 9;
  localparam int POS_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [FUNC_W-1:0] FN_READ       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } brd_state_t;

  typedef struct packed {
    logic take;       // transaction accepted this cycle
    logic result_out; // result transaction completes this cycle
  } brd_cmd_t;

endpackage

>>> rtl/brd_ctrl.sv
// Handshake controller: owns the result slot and issues the accept command.
module brd_ctrl import brd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output brd_cmd_t cmd
);

  brd_state_t state_r, state_nxt;

  assign out_tvalid     = (state_r == ST_HOLD);
  // slot frees the same cycle the receiver takes it
  assign in_tready      = (state_r == ST_IDLE) || out_tready;
  assign cmd.take       = in_tvalid && in_tready;
  assign cmd.result_out = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (cmd.take) state_nxt = ST_HOLD;
        else if (cmd.result_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

>>> rtl/brd_datapath.sv
// Deque datapath: indices, fill count, push-run tracking and the byte store.
module brd_datapath import brd_pkg::*; #(
  parameter int DEPTH = BRD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  brd_cmd_t          cmd,
  input  logic [FUNC_W-1:0] func,
  input  logic [CNT_W-1:0]  count,
  input  logic [POS_W-1:0]  position,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              ok,
  output logic [BYTE_W-1:0] read_byte,
  output logic [CNT_W-1:0]  fill_level
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = ((FW > CNT_W) ? FW : CNT_W) + 1;
  localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);
  localparam logic [AW-1:0] ONE_A   = AW'(1);

  // (a + b) mod DEPTH, valid while a + b < 2*DEPTH
  function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] a, input logic [AW-1:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + b;
    if (s >= DEPTH_A) s = s - DEPTH_A;
    return s[IW-1:0];
  endfunction

  // (a - b) mod DEPTH, valid while b <= DEPTH
  function automatic logic [IW-1:0] sub_mod(input logic [IW-1:0] a, input logic [AW-1:0] b);
    logic [AW-1:0] s;
    if (AW'(a) >= b) s = AW'(a) - b;
    else s = AW'(a) + DEPTH_A - b;
    return s[IW-1:0];
  endfunction

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    back_r, back_nxt;
  logic [IW-1:0]    wp_r, wp_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0] run_rem_r, run_rem_nxt;
  logic             run_acc_r, run_acc_nxt;
  logic             ok_r, ok_nxt;
  logic             is_rd_r, is_rd_nxt;

  logic [AW-1:0]    count_a, fill_a, pos_a;
  logic             run_cont, is_push;
  logic             we;
  logic [IW-1:0]    waddr, raddr;

  assign count_a  = AW'(count);
  assign fill_a   = AW'(fill_r);
  assign pos_a    = AW'(position);
  assign is_push  = (func == FN_PUSH_FRONT) || (func == FN_PUSH_BACK);
  assign run_cont = (run_rem_r != '0) && is_push;
  assign raddr    = add_mod(front_r, pos_a);

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    run_rem_nxt = run_rem_r;
    run_acc_nxt = run_acc_r;
    ok_nxt      = 1'b0;
    is_rd_nxt   = 1'b0;
    we          = 1'b0;
    waddr       = wp_r;
    if (run_cont) begin
      // next byte of an open run, whatever its push direction and count
      if (run_acc_r) begin
        we     = 1'b1;
        wp_nxt = add_mod(wp_r, ONE_A);
      end
      run_rem_nxt = run_rem_r - CNT_W'(1);
      ok_nxt      = run_acc_r;
    end else begin
      run_rem_nxt = '0;
      case (func)
        FN_READ: begin
          is_rd_nxt = 1'b1;
          ok_nxt    = (pos_a < fill_a);
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if ((count != '0) && (count_a <= fill_a)) begin
            if (func == FN_POP_FRONT) front_nxt = add_mod(front_r, count_a);
            else back_nxt = sub_mod(back_r, count_a);
            fill_nxt = FW'(fill_a - count_a);
            ok_nxt   = 1'b1;
          end
        end
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          run_rem_nxt = (count != '0) ? count - CNT_W'(1) : '0;
          if ((count != '0) && (fill_a + count_a <= DEPTH_A)) begin
            if (func == FN_PUSH_FRONT) begin
              front_nxt = sub_mod(front_r, count_a);
              waddr     = front_nxt;
            end else begin
              waddr    = add_mod(back_r, ONE_A);
              back_nxt = add_mod(back_r, count_a);
            end
            we          = 1'b1;
            wp_nxt      = add_mod(waddr, ONE_A);
            fill_nxt    = FW'(fill_a + count_a);
            run_acc_nxt = 1'b1;
            ok_nxt      = 1'b1;
          end else begin
            run_acc_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      back_r    <= IW'(DEPTH - 1);
      wp_r      <= '0;
      fill_r    <= '0;
      run_rem_r <= '0;
      run_acc_r <= 1'b0;
    end else if (cmd.take) begin
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      run_rem_r <= run_rem_nxt;
      run_acc_r <= run_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ok_r    <= ok_nxt;
      is_rd_r <= is_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && we) mem[waddr] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) rdata_r <= mem[raddr];
  end

  assign ok         = ok_r;
  assign read_byte  = (ok_r && is_rd_r) ? rdata_r : '0;
  // fill count only moves on an accept, which also refreshes the result slot
  assign fill_level = CNT_W'(fill_r);

endmodule

>>> rtl/byte_ring_deque.sv
// Top level of the byte ring deque: stream ports, controller and datapath.
//
// Usage:
//   Input stream (in_*): one transaction per operation. func selects read at
//   offset, pop front, pop back, push front or push back. A push is a run of
//   count transactions, one byte each, in array order; space is checked on
//   the first one and a run that does not fit is dropped whole.
//   Result stream (out_*): exactly one transaction per input transaction,
//   in order: ok, the byte read (reads only) and the fill level afterwards.
// Result timing: the result is valid the cycle after the input is accepted;
//   the byte store read port is registered.
// Throughput: one transaction per cycle while the receiver keeps out_tready
//   high; the single result register is refilled the same cycle it drains.
// Stall: while a result waits with out_tready low, in_tready is low and the
//   result and all deque state hold.
// Reset (rst_n low, synchronous): deque empty, no run open, result slot
//   empty. The byte store is not cleared; no pass after reset is needed.
`include "byte_ring_deque_assert.svh"

module byte_ring_deque import brd_pkg::*; #(
  parameter int DEPTH = BRD_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] func, [11:3] count, [19:12] position, [27:20] data_byte, [31:28] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] ok, [8:1] read_byte, [17:9] fill_level, [23:18] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  brd_cmd_t          cmd;
  logic              ok;
  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  fill_level;

  // Handshake and result-slot control
  brd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Indices, run state and byte store
  brd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .func       (in_tdata[2:0]),
    .count      (in_tdata[11:3]),
    .position   (in_tdata[19:12]),
    .data_byte  (in_tdata[27:20]),
    .ok         (ok),
    .read_byte  (read_byte),
    .fill_level (fill_level)
  );

  assign out_tdata = {6'd0, fill_level, read_byte, ok};

  // Every accepted transaction shows a result on the next cycle
  `BRD_ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)
  // A waiting result is never overwritten by a new transaction
  `BRD_ASSERT_IMPL(a_no_overrun, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  // A failed operation never carries a data byte
  `BRD_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[8:1] == 8'd0)

endmodule
